// ===== design/great_circle_initial_bearing_core_macros.svh =====
// Assertion macros for the great-circle bearing core.
`ifndef GREAT_CIRCLE_INITIAL_BEARING_CORE_MACROS_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_CORE_MACROS_SVH

`ifndef SYNTH
// lbl: label, ck: clock, rn: active-low reset, a: condition, c: consequence
`define GCIB_ASSERT_NOW(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("bearing core assertion failed");
`define GCIB_ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("bearing core assertion failed");
`else
`define GCIB_ASSERT_NOW(lbl, ck, rn, a, c)
`define GCIB_ASSERT_NEXT(lbl, ck, rn, a, c)
`endif

`endif

// ===== design/gcib_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table.
package gcib_pkg;

    localparam int WORK_BITS          = 30;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF   = 18;
    localparam int DEG_SCALE_BITS     = 24;
    localparam int OUT_WIDTH          = 25;

    localparam longint Q_ONE     = 64'sd1073741824;
    localparam longint Q_PI      = 64'sd3373259426;
    localparam longint Q_HALF_PI = 64'sd1686629713;
    localparam longint Q_TWO_PI  = 64'sd6746518852;
    localparam longint Q_GAIN    = 64'sd652032874;
    localparam longint DEG_SCALE = 64'sd961263669;

    // rotation datapath widths (Q.30)
    localparam int ROT_XW = 34;
    localparam int ROT_AW = 34;
    localparam int TRIG_W = 32;
    // vectoring datapath widths
    localparam int VEC_XW = 36;
    localparam int VEC_ZW = 34;

    typedef struct packed {
        logic neg;
        logic zero;
    } lane_flags_t;

    typedef struct packed {
        lane_flags_t lat1;
        lane_flags_t lat2;
        lane_flags_t dlon;
    } trig_flags_t;

    function automatic longint arc_angle(input int i);
        longint r;
        case (i)
            0:  r = 843314856;
            1:  r = 497837829;
            2:  r = 263043836;
            3:  r = 133525158;
            4:  r = 67021686;
            5:  r = 33543515;
            6:  r = 16775850;
            7:  r = 8388437;
            8:  r = 4194282;
            9:  r = 2097149;
            10: r = 1048575;
            11: r = 524287;
            12: r = 262143;
            13: r = 131071;
            14: r = 65535;
            15: r = 32767;
            16: r = 16383;
            17: r = 8191;
            18: r = 4095;
            19: r = 2047;
            20: r = 1023;
            21: r = 511;
            22: r = 255;
            23: r = 127;
            24: r = 63;
            25: r = 31;
            26: r = 15;
            27: r = 7;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/great_circle_initial_bearing_core.sv =====
// Top level: pipelined initial great-circle bearing from two points.
//
//   group   dir  payload (tdata, low bit first)                  width
//   s_axis  in   start_lat 18, start_lon 19, end_lat 18, end_lon 19  80
//   m_axis  out  bearing_degrees 25 (unsigned, deg)                  32
//
// One transaction per cycle sustained while m_axis takes results; the two
// CORDIC pipelines (rotation, then vectoring) form most of the pipeline.
// rst_n clears only the valid bits; payload registers are not reset.
// Whole pipeline advances together; it freezes only while the output
// register holds a transaction that m_axis has not taken, so s_axis_tready
// stays high through bubbles and a stall drops or repeats nothing.
module great_circle_initial_bearing_core
    import gcib_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_latitude[17:0], start_longitude[36:18], end_latitude[54:37],
    // end_longitude[73:55], zero pad[79:74]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bearing_degrees[24:0], zero pad[31:25]
    output logic [31:0] m_axis_tdata
);

`include "great_circle_initial_bearing_core_macros.svh"

    localparam int LOAD_SH = WORK_BITS - FRACTION_BITS;
    localparam int AW      = 21 + LOAD_SH;    // scaled angle incl. difference
    localparam int DEG_SH  = WORK_BITS + DEG_SCALE_BITS - FRACTION_BITS;
    localparam int PW      = 66;
    localparam longint FULL = 64'sd360 <<< FRACTION_BITS;

    logic adv;
    logic out_vld_reg;
    logic [OUT_WIDTH-1:0] bearing_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(32 - OUT_WIDTH){1'b0}}, bearing_reg};

    // ---------------- stage 1: scale to Q.30, longitude difference
    logic signed [17:0] in_lat1, in_lat2;
    logic signed [18:0] in_lon1, in_lon2;
    assign in_lat1 = s_axis_tdata[17:0];
    assign in_lon1 = s_axis_tdata[36:18];
    assign in_lat2 = s_axis_tdata[54:37];
    assign in_lon2 = s_axis_tdata[73:55];

    logic signed [AW-1:0] ang1_reg [0:2];
    logic v1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang1_reg[0] <= AW'(in_lat1) <<< LOAD_SH;
            ang1_reg[1] <= AW'(in_lat2) <<< LOAD_SH;
            ang1_reg[2] <= (AW'(in_lon2) - AW'(in_lon1)) <<< LOAD_SH;
        end
    end

    // ---------------- stage 2: wrap into [-pi, pi]
    logic signed [AW-1:0] ang2_reg [0:2];
    logic v2_reg;

    for (genvar k = 0; k < 3; k++) begin : g_wrap
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                priority if (longint'(ang1_reg[k]) > Q_PI)
                    ang2_reg[k] <= ang1_reg[k] - AW'(Q_TWO_PI);
                else if (longint'(ang1_reg[k]) < -Q_PI)
                    ang2_reg[k] <= ang1_reg[k] + AW'(Q_TWO_PI);
                else
                    ang2_reg[k] <= ang1_reg[k];
            end
        end
    end

    // ---------------- stage 3: fold into [-pi/2, pi/2]
    logic signed [ROT_AW-1:0] red_next [0:2];
    logic signed [ROT_AW-1:0] red_reg  [0:2];
    lane_flags_t              lf_next  [0:2];
    trig_flags_t              flg3_reg;
    logic v3_reg;

    for (genvar k = 0; k < 3; k++) begin : g_fold
        logic signed [AW-1:0] f;
        always_comb
        begin
            f = ang2_reg[k];
            lf_next[k].neg = 1'b0;
            priority if (longint'(ang2_reg[k]) > Q_HALF_PI)
            begin
                f = ang2_reg[k] - AW'(Q_PI);
                lf_next[k].neg = 1'b1;
            end
            else if (longint'(ang2_reg[k]) < -Q_HALF_PI)
            begin
                f = ang2_reg[k] + AW'(Q_PI);
                lf_next[k].neg = 1'b1;
            end
            else
            begin
                f = ang2_reg[k];
            end
            red_next[k]     = ROT_AW'(f);
            lf_next[k].zero = (f == '0);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                red_reg[k] <= red_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            flg3_reg <= '{lat1: lf_next[0], lat2: lf_next[1], dlon: lf_next[2]};
    end

    // ---------------- rotation CORDIC, three lanes
    logic signed [ROT_XW-1:0] sin1, cos1, sin2, cos2, sind, cosd;

    gcib_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat1 (
        .clk(clk), .adv(adv), .ang_in(red_reg[0]), .sin_out(sin1), .cos_out(cos1)
    );
    gcib_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat2 (
        .clk(clk), .adv(adv), .ang_in(red_reg[1]), .sin_out(sin2), .cos_out(cos2)
    );
    gcib_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
        .clk(clk), .adv(adv), .ang_in(red_reg[2]), .sin_out(sind), .cos_out(cosd)
    );

    trig_flags_t rflg_reg [0:CORDIC_STEPS-1];
    logic [CORDIC_STEPS-1:0] rvld_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rflg_reg[0] <= flg3_reg;
            for (int k = 1; k < CORDIC_STEPS; k++)
                rflg_reg[k] <= rflg_reg[k-1];
        end
    end

    // ---------------- stage 4: quadrant sign and exact zero angle
    function automatic logic signed [TRIG_W-1:0] fix_sin(
        input logic signed [ROT_XW-1:0] y, input lane_flags_t f);
        logic signed [TRIG_W-1:0] r;
        r = TRIG_W'(y);
        if (f.zero)
            return '0;
        return f.neg ? -r : r;
    endfunction

    function automatic logic signed [TRIG_W-1:0] fix_cos(
        input logic signed [ROT_XW-1:0] x, input lane_flags_t f);
        logic signed [TRIG_W-1:0] r;
        r = f.zero ? TRIG_W'(Q_ONE) : TRIG_W'(x);
        return f.neg ? -r : r;
    endfunction

    logic signed [TRIG_W-1:0] s1_reg, c1_reg, s2_reg, c2_reg, sd_reg, cd_reg;
    logic v4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= fix_sin(sin1, rflg_reg[CORDIC_STEPS-1].lat1);
            c1_reg <= fix_cos(cos1, rflg_reg[CORDIC_STEPS-1].lat1);
            s2_reg <= fix_sin(sin2, rflg_reg[CORDIC_STEPS-1].lat2);
            c2_reg <= fix_cos(cos2, rflg_reg[CORDIC_STEPS-1].lat2);
            sd_reg <= fix_sin(sind, rflg_reg[CORDIC_STEPS-1].dlon);
            cd_reg <= fix_cos(cosd, rflg_reg[CORDIC_STEPS-1].dlon);
        end
    end

    // ---------------- stage 5: first products
    logic signed [2*TRIG_W-1:0] m_east, m_p1, m_p2;
    assign m_east = c2_reg * sd_reg;
    assign m_p1   = c1_reg * s2_reg;
    assign m_p2   = s1_reg * c2_reg;

    logic signed [TRIG_W+1:0] east5_reg, p1_5_reg;
    logic signed [TRIG_W-1:0] p2_reg, cd5_reg;
    logic v5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            east5_reg <= (TRIG_W+2)'(m_east >>> WORK_BITS);
            p1_5_reg  <= (TRIG_W+2)'(m_p1 >>> WORK_BITS);
            p2_reg    <= TRIG_W'(m_p2 >>> WORK_BITS);
            cd5_reg   <= cd_reg;
        end
    end

    // ---------------- stage 6: second product
    logic signed [2*TRIG_W-1:0] m_t;
    assign m_t = p2_reg * cd5_reg;

    logic signed [TRIG_W+1:0] east6_reg, p1_6_reg, t_reg;
    logic v6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= (TRIG_W+2)'(m_t >>> WORK_BITS);
            east6_reg <= east5_reg;
            p1_6_reg  <= p1_5_reg;
        end
    end

    // ---------------- stage 7: north term
    logic signed [TRIG_W+1:0] east7_reg, north_reg;
    logic v7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            north_reg <= p1_6_reg - t_reg;
            east7_reg <= east6_reg;
        end
    end

    // ---------------- stage 8: quarter turn for the left half plane
    logic signed [VEC_XW-1:0] ve, vn;
    assign ve = VEC_XW'(east7_reg);
    assign vn = VEC_XW'(north_reg);

    logic signed [VEC_XW-1:0] vx_reg, vy_reg;
    logic signed [VEC_ZW-1:0] vz_reg;
    logic vzero_reg;
    logic v8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vzero_reg <= (vn == '0) && (ve == '0);
            priority if (!vn[VEC_XW-1])
            begin
                vx_reg <= vn;
                vy_reg <= ve;
                vz_reg <= '0;
            end
            else if (!ve[VEC_XW-1])
            begin
                vx_reg <= ve;
                vy_reg <= -vn;
                vz_reg <= VEC_ZW'(Q_HALF_PI);
            end
            else
            begin
                vx_reg <= -ve;
                vy_reg <= vn;
                vz_reg <= -VEC_ZW'(Q_HALF_PI);
            end
        end
    end

    // ---------------- vectoring CORDIC
    logic signed [VEC_ZW-1:0] z_vec;

    gcib_vec #(.STEPS(CORDIC_STEPS)) u_vec (
        .clk(clk), .adv(adv), .x_in(vx_reg), .y_in(vy_reg), .z_in(vz_reg),
        .z_out(z_vec)
    );

    logic [CORDIC_STEPS-1:0] vzd_reg;
    logic [CORDIC_STEPS-1:0] vvld_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            vzd_reg <= {vzd_reg[CORDIC_STEPS-2:0], vzero_reg};
    end

    // ---------------- stage 9: scale to degrees, add rounding half
    logic signed [PW-1:0] prod_reg;
    logic v9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vzd_reg[CORDIC_STEPS-1])
                prod_reg <= PW'(64'sd1 <<< (DEG_SH - 1));
            else
                prod_reg <= PW'(z_vec) * PW'(DEG_SCALE) + PW'(64'sd1 <<< (DEG_SH - 1));
        end
    end

    // ---------------- stage 10: wrap and saturate into [0, 360)
    logic signed [PW-1:0] deg_raw, deg_wrap;

    always_comb
    begin
        deg_raw  = prod_reg >>> DEG_SH;
        deg_wrap = deg_raw[PW-1] ? deg_raw + PW'(FULL) : deg_raw;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (deg_wrap >= PW'(FULL))
                bearing_reg <= OUT_WIDTH'(FULL - 64'sd1);
            else if (deg_wrap[PW-1])
                bearing_reg <= '0;
            else
                bearing_reg <= OUT_WIDTH'(deg_wrap);
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            rvld_reg    <= '0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            vvld_reg    <= '0;
            v9_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= s_axis_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            rvld_reg    <= {rvld_reg[CORDIC_STEPS-2:0], v3_reg};
            v4_reg      <= rvld_reg[CORDIC_STEPS-1];
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            vvld_reg    <= {vvld_reg[CORDIC_STEPS-2:0], v8_reg};
            v9_reg      <= vvld_reg[CORDIC_STEPS-1];
            out_vld_reg <= v9_reg;
        end
    end

    // ---------------- checks
    `GCIB_ASSERT_NOW(a_bearing_range, clk, rst_n, out_vld_reg, longint'(bearing_reg) < FULL)
    `GCIB_ASSERT_NEXT(a_stall_keeps_out, clk, rst_n, !adv, out_vld_reg)
    `GCIB_ASSERT_NEXT(a_last_stage_moves, clk, rst_n, adv && v9_reg, out_vld_reg)
    `GCIB_ASSERT_NEXT(a_stall_no_new, clk, rst_n, !adv && !v1_reg, !v1_reg)

endmodule

// ===== design/gcib_rot.sv =====
// Pipelined CORDIC rotator: one micro-rotation per register stage.
module gcib_rot
    import gcib_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [ROT_AW-1:0] ang_in,
    output logic signed [ROT_XW-1:0] sin_out,
    output logic signed [ROT_XW-1:0] cos_out
);

    logic signed [ROT_XW-1:0] x_reg [0:STEPS-1];
    logic signed [ROT_XW-1:0] y_reg [0:STEPS-1];
    logic signed [ROT_AW-1:0] a_reg [0:STEPS-1];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [ROT_XW-1:0] x_cur;
        logic signed [ROT_XW-1:0] y_cur;
        logic signed [ROT_AW-1:0] a_cur;
        logic signed [ROT_AW-1:0] arc;

        if (i == 0) begin : g_first
            assign x_cur = ROT_XW'(Q_GAIN);
            assign y_cur = '0;
            assign a_cur = ang_in;
        end
        else begin : g_next
            assign x_cur = x_reg[i-1];
            assign y_cur = y_reg[i-1];
            assign a_cur = a_reg[i-1];
        end

        assign arc = ROT_AW'(arc_angle(i));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!a_cur[ROT_AW-1])
                begin
                    x_reg[i] <= x_cur - (y_cur >>> i);
                    y_reg[i] <= y_cur + (x_cur >>> i);
                    a_reg[i] <= a_cur - arc;
                end
                else
                begin
                    x_reg[i] <= x_cur + (y_cur >>> i);
                    y_reg[i] <= y_cur - (x_cur >>> i);
                    a_reg[i] <= a_cur + arc;
                end
            end
        end
    end

    assign sin_out = y_reg[STEPS-1];
    assign cos_out = x_reg[STEPS-1];

endmodule

// ===== design/gcib_vec.sv =====
// Pipelined CORDIC vectoring unit: drives y to zero, accumulates the angle.
module gcib_vec
    import gcib_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [VEC_XW-1:0] x_in,
    input  logic signed [VEC_XW-1:0] y_in,
    input  logic signed [VEC_ZW-1:0] z_in,
    output logic signed [VEC_ZW-1:0] z_out
);

    logic signed [VEC_XW-1:0] x_reg [0:STEPS-1];
    logic signed [VEC_XW-1:0] y_reg [0:STEPS-1];
    logic signed [VEC_ZW-1:0] z_reg [0:STEPS-1];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [VEC_XW-1:0] x_cur;
        logic signed [VEC_XW-1:0] y_cur;
        logic signed [VEC_ZW-1:0] z_cur;
        logic signed [VEC_ZW-1:0] arc;

        if (i == 0) begin : g_first
            assign x_cur = x_in;
            assign y_cur = y_in;
            assign z_cur = z_in;
        end
        else begin : g_next
            assign x_cur = x_reg[i-1];
            assign y_cur = y_reg[i-1];
            assign z_cur = z_reg[i-1];
        end

        assign arc = VEC_ZW'(arc_angle(i));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_cur[VEC_XW-1])
                begin
                    x_reg[i] <= x_cur + (y_cur >>> i);
                    y_reg[i] <= y_cur - (x_cur >>> i);
                    z_reg[i] <= z_cur + arc;
                end
                else
                begin
                    x_reg[i] <= x_cur - (y_cur >>> i);
                    y_reg[i] <= y_cur + (x_cur >>> i);
                    z_reg[i] <= z_cur - arc;
                end
            end
        end
    end

    assign z_out = z_reg[STEPS-1];

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the great-circle initial bearing core: random and directed points.
`timescale 1ns / 1ps

class bearing_scoreboard;
    logic [24:0] pending_bearings[$];
    int          mismatch_count;
    int          checked_count;

    function void note_point_pair(logic [24:0] bearing);
        pending_bearings.push_back(bearing);
    endfunction

    function void check_bearing(logic [31:0] tdata);
        logic [24:0] want;
        if (pending_bearings.size() == 0)
        begin
            $display("%0t: unexpected bearing %0d", $time, tdata[24:0]);
            mismatch_count++;
            return;
        end
        want = pending_bearings.pop_front();
        checked_count++;
        if (tdata[24:0] !== want || tdata[31:25] !== 7'd0)
        begin
            $display("%0t: bearing mismatch expected %0d actual %0d (pad %0h)",
                     $time, want, tdata[24:0], tdata[31:25]);
            mismatch_count++;
        end
    endfunction
endclass

module tb_top
    import gcib_pkg::*;
();

    localparam int FRAC     = 16;
    localparam int STEPS    = 18;
    localparam int LATENCY  = 2 * STEPS + 10;
    localparam int WATCHDOG = 5000;
    localparam longint LAT_MAX = 102944;
    localparam longint LON_MAX = 205888;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    bearing_scoreboard sb = new();
    bit   no_idle = 1'b0;
    bit   timed_out = 1'b0;
    int   idle_cycles = 0;
    int   sent_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    great_circle_initial_bearing_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // ---- predictor: fixed-point CORDIC bearing ----
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;   // arithmetic shift on signed is floor
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return floor_shr(a * b, WORK_BITS);
    endfunction

    function automatic longint to_q30(logic [18:0] raw, int width);
        longint v;
        v = (raw[width-1]) ? longint'(raw[18:0] & ((19'd1 << width) - 1)) - (64'sd1 << width)
                           : longint'(raw[18:0] & ((19'd1 << width) - 1));
        return v * (64'sd1 << (WORK_BITS - FRAC));
    endfunction

    function automatic void rotate_sincos(input longint ang, output longint s,
                                          output longint c);
        bit     flip;
        longint x, y, dx, dy;
        flip = 1'b0;
        x = Q_GAIN;
        y = 0;
        while (ang > Q_PI) ang -= Q_TWO_PI;
        while (ang < -Q_PI) ang += Q_TWO_PI;
        if (ang > Q_HALF_PI)
        begin
            ang -= Q_PI;
            flip = 1'b1;
        end
        else if (ang < -Q_HALF_PI)
        begin
            ang += Q_PI;
            flip = 1'b1;
        end
        if (ang == 0)
        begin
            s = 0;
            c = flip ? -Q_ONE : Q_ONE;
            return;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (ang >= 0)
            begin
                x -= dx; y += dy; ang -= arc_angle(i);
            end
            else
            begin
                x += dx; y -= dy; ang += arc_angle(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint heading_angle(longint north, longint east);
        longint x, y, z, t, dx, dy;
        x = north; y = east; z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = Q_HALF_PI;
            end
            else
            begin
                x = -y; y = t; z = -Q_HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_angle(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_angle(i);
            end
        end
        return z;
    endfunction

    function automatic logic [24:0] predict_bearing(logic [79:0] d);
        longint lat1, lon1, lat2, lon2, s1, c1, s2, c2, sd, cd, east, north, z, deg;
        longint full;
        int     sh;
        sh = WORK_BITS + DEG_SCALE_BITS - FRAC;
        full = 64'sd360 << FRAC;
        lat1 = to_q30({1'b0, d[17:0]}, 18);
        lon1 = to_q30(d[36:18], 19);
        lat2 = to_q30({1'b0, d[54:37]}, 18);
        lon2 = to_q30(d[73:55], 19);
        rotate_sincos(lat1, s1, c1);
        rotate_sincos(lat2, s2, c2);
        rotate_sincos(lon2 - lon1, sd, cd);
        east = q_mul(c2, sd);
        north = q_mul(c1, s2) - q_mul(q_mul(s1, c2), cd);
        z = heading_angle(north, east);
        deg = floor_shr(z * DEG_SCALE + (64'sd1 <<< (sh - 1)), sh);
        if (deg < 0) deg += full;
        if (deg >= full) deg = full - 1;
        if (deg < 0) deg = 0;
        return deg[24:0];
    endfunction

    function automatic logic [79:0] pack_points(longint la1, longint lo1, longint la2,
                                                longint lo2);
        logic [17:0] a;
        logic [18:0] b;
        logic [17:0] c;
        logic [18:0] e;
        a = la1[17:0]; b = lo1[18:0]; c = la2[17:0]; e = lo2[18:0];
        return {6'd0, e, c, b, a};
    endfunction

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    // send one point pair; valid held until the transaction is taken,
    // dropped only for idle cycles
    task automatic send_points(logic [79:0] d);
        if (!no_idle)
            while ($urandom_range(99) < 36)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_point_pair(predict_bearing(d));
        sent_count++;
        @(negedge clk);
    endtask

    // result side: random stalls, sampled at the rising edge
    always @(negedge clk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_bearing(m_axis_tdata);
    end

    // watchdog: counts cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d bearings outstanding",
                     sb.pending_bearings.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        longint ends[4];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, coincident points, poles, antimeridian, raw patterns
        send_points(pack_points(0, 0, 0, 0));
        send_points(pack_points(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
        send_points(pack_points(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX));
        send_points(pack_points(0, 0, LAT_MAX, 0));
        send_points(pack_points(0, 0, -LAT_MAX, 0));
        send_points(pack_points(0, 0, 0, 1000));
        send_points(pack_points(0, 0, 0, -1000));
        send_points(pack_points(0, -LON_MAX, 0, LON_MAX));
        send_points(pack_points(0, LON_MAX, 0, -LON_MAX));
        send_points(pack_points(LAT_MAX, 0, -LAT_MAX, 0));
        send_points(pack_points(-LAT_MAX, 0, LAT_MAX, 12345));
        send_points(pack_points(30000, 10000, -20000, 9000));     // south-west, north < 0
        send_points(pack_points(30000, 10000, -20000, 11000));    // south-east
        send_points(pack_points(0, 0, 0, 102944));
        send_points(pack_points(40000, 0, 40000, 1));
        send_points(pack_points(1, 0, 0, 0));
        send_points({6'd0, 19'h7FFFF, 18'h3FFFF, 19'h7FFFF, 18'h3FFFF});
        send_points({6'd0, 19'h3FFFF, 18'h1FFFF, 19'h40000, 18'h20000});
        send_points({6'd0, 19'h40000, 18'h20000, 19'h3FFFF, 18'h1FFFF});
        send_points({6'd0, 19'h2AAAA, 18'h15555, 19'h55555, 18'h2AAAA});

        // random: mostly in range, some raw bit patterns and near pairs
        for (int n = 0; n < 1030; n++)
        begin
            no_idle = (n >= 400 && n < 550);
            case ($urandom_range(9))
                0: send_points({6'd0, 74'($urandom()) | (74'($urandom()) << 32)
                                      | (74'($urandom()) << 64)});
                1:
                begin
                    ends[0] = rand_span(LAT_MAX);
                    ends[1] = rand_span(LON_MAX);
                    send_points(pack_points(ends[0], ends[1],
                                            ends[0] + rand_span(50),
                                            ends[1] + rand_span(50)));
                end
                default:
                    send_points(pack_points(rand_span(LAT_MAX), rand_span(LON_MAX),
                                            rand_span(LAT_MAX), rand_span(LON_MAX)));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_bearings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d point pairs, checked %0d bearings, %0d mismatches.",
                 sent_count, sb.checked_count, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.pending_bearings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
